// File: src/kfsm_pkg.sv
// Shared types, constants and helper functions for the keyframe blend core.
// Used by every module under src; depends on nothing.
package kfsm_pkg;

  localparam int CORDIC_STEPS   = 16;
  localparam int ATAN_LEN       = 24;
  localparam int STEP_CNT       = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int QUAT_FRAC_BITS = 14;
  localparam int IN_SHIFT       = 30 - QUAT_FRAC_BITS;
  localparam int IN_DIV_SHIFT   = 45;
  localparam int NQ_DIV_SHIFT   = 29;
  localparam int SQRT_STEPS     = 32;
  localparam int DIV_QBITS      = 34;

  localparam longint unsigned NEAR_ZERO_IN =
    (64'd1 << (2 * QUAT_FRAC_BITS)) / 64'd1000000000000;
  localparam longint unsigned NEAR_ZERO_Q58 = 64'd288230;

  typedef logic signed [35:0] word_t;
  typedef logic signed [71:0] acc_t;

  localparam acc_t ONE_Q30 = 72'sd1 <<< 30;
  localparam acc_t ONE_Q60 = 72'sd1 <<< 60;
  localparam acc_t ENT_MAX = 72'sd65536;

  function automatic word_t atan_q30(input logic [4:0] i);
    word_t v;
    case (i)
      5'd0:  v = 36'sd843314857;
      5'd1:  v = 36'sd497837829;
      5'd2:  v = 36'sd263043837;
      5'd3:  v = 36'sd133525159;
      5'd4:  v = 36'sd67021679;
      5'd5:  v = 36'sd33543516;
      5'd6:  v = 36'sd16775851;
      5'd7:  v = 36'sd8388437;
      5'd8:  v = 36'sd4194283;
      5'd9:  v = 36'sd2097149;
      5'd10: v = 36'sd1048576;
      5'd11: v = 36'sd524288;
      5'd12: v = 36'sd262144;
      5'd13: v = 36'sd131072;
      5'd14: v = 36'sd65536;
      5'd15: v = 36'sd32768;
      5'd16: v = 36'sd16384;
      5'd17: v = 36'sd8192;
      5'd18: v = 36'sd4096;
      5'd19: v = 36'sd2048;
      5'd20: v = 36'sd1024;
      5'd21: v = 36'sd512;
      5'd22: v = 36'sd256;
      5'd23: v = 36'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic acc_t rsh_round(input acc_t x, input int n);
    logic [71:0] m;
    m = x[71] ? 72'(-x) : 72'(x);
    m = (m + (72'd1 << (n - 1))) >> n;
    return x[71] ? acc_t'(-m) : acc_t'(m);
  endfunction

  function automatic logic [17:0] ent_out(input acc_t q60);
    acc_t v;
    v = rsh_round(q60, 44);
    if (v > ENT_MAX) begin
      v = ENT_MAX;
    end else if (v < -ENT_MAX) begin
      v = -ENT_MAX;
    end
    return v[17:0];
  endfunction

endpackage

// File: src/kfsm_mul.sv
// Shared signed multiplier with a registered product.
// Depends on kfsm_pkg.
module kfsm_mul
  import kfsm_pkg::*;
(
  input  logic  clk,
  input  word_t mul_a,
  input  word_t mul_b,
  output acc_t  prod_r
);

  acc_t prod_nxt;

  assign prod_nxt = acc_t'(mul_a) * acc_t'(mul_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// File: src/kfsm_sqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on kfsm_pkg.
module kfsm_sqrt
  import kfsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] val,
  output logic        done_r,
  output logic [31:0] root
);

  localparam int CW = $clog2(SQRT_STEPS);

  logic          busy_r, busy_nxt;
  logic          done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [63:0]   v_r, v_nxt, res_r, res_nxt, bit_r, bit_nxt, t;

  assign root = res_r[31:0];
  assign t    = res_r + bit_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    v_nxt    = v_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      v_nxt    = val;
      res_nxt  = '0;
      bit_nxt  = 64'd1 << 62;
    end else if (busy_r) begin
      if (v_r >= t) begin
        v_nxt   = v_r - t;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(SQRT_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

endmodule

// File: src/kfsm_div.sv
// Iterative rounding divider, signed numerator by unsigned length, one bit per cycle.
// Depends on kfsm_pkg.
module kfsm_div
  import kfsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic        [32:0] den,
  output logic               done_r,
  output word_t              quot
);

  localparam int CW = $clog2(DIV_QBITS);

  logic                 busy_r, busy_nxt, done_nxt, neg_r, neg_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [63:0]          rem_r, rem_nxt, mag, t;
  logic [DIV_QBITS-1:0] sh_r, sh_nxt, q_r, q_nxt;
  logic [32:0]          den_r, den_nxt;
  word_t                qw;

  assign mag  = (num[63] ? 64'(-num) : 64'(num)) + 64'(den >> 1);
  assign t    = {rem_r[62:0], sh_r[DIV_QBITS-1]};
  assign qw   = word_t'(q_r);
  assign quot = (den_r == '0) ? '0 : (neg_r ? -qw : qw);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = num[63];
      rem_nxt  = mag >> DIV_QBITS;
      sh_nxt   = mag[DIV_QBITS-1:0];
      q_nxt    = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      if (t >= 64'(den_r)) begin
        rem_nxt = t - 64'(den_r);
        q_nxt   = {q_r[DIV_QBITS-2:0], 1'b1};
      end else begin
        rem_nxt = t;
        q_nxt   = {q_r[DIV_QBITS-2:0], 1'b0};
      end
      sh_nxt  = sh_r << 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DIV_QBITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

endmodule

// File: src/keyframe_slerp_bone_matrix_core.sv
// Keyframe blend core: slerp or normalized linear blend to a 3x3 bone matrix.
// Kind-0 beat: stored on acceptance. Kind-1 beat: runs the sequencer from accept to out_tvalid on the
// linear or slerp path; its run time is set by twelve divides and three (linear)
// or four (slerp) roots; a near-zero quaternion skips its root and its divides.
// One item at a time; the next beat is taken while the result waits in the output register.
// Reset (synchronous, active low) clears the held keyframe and restores the threshold.
module keyframe_slerp_bone_matrix_core
  import kfsm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [16:0]  cfg_data,   // nlerp_threshold
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic         in_tuser,   // kind
  input  logic [183:0] in_tdata,   // quat_x, quat_y, quat_z, quat_w, offset_x, offset_y,
                                   // offset_z, alpha
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [263:0] out_tdata   // r00, r01, r02, r10, r11, r12, r20, r21, r22,
                                   // move_x, move_y, move_z
);

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_INSQ    = 5'd1;
  localparam logic [4:0] ST_INSQRT  = 5'd2;
  localparam logic [4:0] ST_INDIV   = 5'd3;
  localparam logic [4:0] ST_DOT     = 5'd4;
  localparam logic [4:0] ST_DOTFIN  = 5'd5;
  localparam logic [4:0] ST_NLERP   = 5'd6;
  localparam logic [4:0] ST_SDSQ    = 5'd7;
  localparam logic [4:0] ST_SSQRT   = 5'd8;
  localparam logic [4:0] ST_CANG    = 5'd9;
  localparam logic [4:0] ST_THETA   = 5'd10;
  localparam logic [4:0] ST_CROT    = 5'd11;
  localparam logic [4:0] ST_W0      = 5'd12;
  localparam logic [4:0] ST_BLEND   = 5'd13;
  localparam logic [4:0] ST_NQCLAMP = 5'd14;
  localparam logic [4:0] ST_NQSQ    = 5'd15;
  localparam logic [4:0] ST_NQSQRT  = 5'd16;
  localparam logic [4:0] ST_NQDIV   = 5'd17;
  localparam logic [4:0] ST_MATP    = 5'd18;
  localparam logic [4:0] ST_OFF     = 5'd19;
  localparam logic [4:0] ST_DONE    = 5'd20;

  localparam word_t CLAMP_HI = 36'sd1 <<< 31;

  logic [4:0]          st_r, st_nxt, idx_r, idx_nxt;
  logic                ph_r, ph_nxt, sel_r, sel_nxt;
  logic signed [15:0]  qa_r [4], qa_nxt [4], qb_r [4], qb_nxt [4];
  logic signed [31:0]  ho_r [3], ho_nxt [3], ob_r [3], ob_nxt [3], mv_r [3], mv_nxt [3];
  logic [16:0]         alpha_r, alpha_nxt, thr_r, thr_nxt;
  word_t               a_r [4], a_nxt [4], b_r [4], b_nxt [4], r_r [4], r_nxt [4];
  acc_t                acc_r, acc_nxt, p_r [9], p_nxt [9];
  logic [32:0]         len_r, len_nxt;
  word_t               dot_r, dot_nxt, sin0_r, sin0_nxt, w0_r, w0_nxt;
  word_t               cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [263:0]        out_tdata_r, out_tdata_nxt;

  word_t               mul_a, mul_b, alpha_w, sx, sy, at, qsel_w;
  acc_t                prod_r, acc_sum, dr, mr;
  logic                sq_start, sq_done, div_start, div_done;
  logic [63:0]         sq_val;
  logic [31:0]         sq_root;
  logic signed [63:0]  div_num;
  word_t               div_quot;
  logic [1:0]          i2;
  logic [3:0]          i4;
  logic signed [15:0]  qsel;
  logic [16:0]         in_alpha;
  logic [17:0]         ent [9];
  logic                in_acc;

  kfsm_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  kfsm_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sq_start),
    .val    (sq_val),
    .done_r (sq_done),
    .root   (sq_root)
  );

  kfsm_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (len_r),
    .done_r (div_done),
    .quot   (div_quot)
  );

  assign cfg_ready  = rst_n;
  assign in_tready  = rst_n && (st_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign i2       = idx_r[1:0];
  assign i4       = idx_r[3:0];
  assign qsel     = sel_r ? qb_r[i2] : qa_r[i2];
  assign qsel_w   = word_t'(qsel);
  assign alpha_w  = word_t'({19'd0, alpha_r});
  assign sx       = cx_r >>> idx_r;
  assign sy       = cy_r >>> idx_r;
  assign at       = atan_q30(idx_r);
  assign in_alpha = (in_tdata[176:160] > 17'd65536) ? 17'd65536 : in_tdata[176:160];

  always_comb begin
    ent[0] = ent_out(ONE_Q60 - 2 * (p_r[1] + p_r[2]));
    ent[1] = ent_out(2 * (p_r[3] + p_r[8]));
    ent[2] = ent_out(2 * (p_r[4] - p_r[7]));
    ent[3] = ent_out(2 * (p_r[3] - p_r[8]));
    ent[4] = ent_out(ONE_Q60 - 2 * (p_r[0] + p_r[2]));
    ent[5] = ent_out(2 * (p_r[5] + p_r[6]));
    ent[6] = ent_out(2 * (p_r[4] + p_r[7]));
    ent[7] = ent_out(2 * (p_r[5] - p_r[6]));
    ent[8] = ent_out(ONE_Q60 - 2 * (p_r[0] + p_r[1]));
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_r)
      ST_INSQ: begin
        mul_a = qsel_w;
        mul_b = qsel_w;
      end
      ST_DOT: begin
        mul_a = a_r[i2];
        mul_b = b_r[i2];
      end
      ST_NLERP: begin
        mul_a = b_r[i2] - a_r[i2];
        mul_b = alpha_w;
      end
      ST_SDSQ: begin
        mul_a = dot_r;
        mul_b = dot_r;
      end
      ST_THETA: begin
        mul_a = cz_r;
        mul_b = alpha_w;
      end
      ST_W0: begin
        mul_a = idx_r[0] ? dot_r : cx_r;
        mul_b = idx_r[0] ? cy_r : sin0_r;
      end
      ST_BLEND: begin
        mul_a = idx_r[0] ? cy_r : w0_r;
        mul_b = idx_r[0] ? b_r[idx_r[2:1]] : a_r[idx_r[2:1]];
      end
      ST_NQSQ: begin
        mul_a = r_r[i2];
        mul_b = r_r[i2];
      end
      ST_MATP: begin
        case (i4)
          4'd0: begin mul_a = r_r[0]; mul_b = r_r[0]; end
          4'd1: begin mul_a = r_r[1]; mul_b = r_r[1]; end
          4'd2: begin mul_a = r_r[2]; mul_b = r_r[2]; end
          4'd3: begin mul_a = r_r[0]; mul_b = r_r[1]; end
          4'd4: begin mul_a = r_r[0]; mul_b = r_r[2]; end
          4'd5: begin mul_a = r_r[1]; mul_b = r_r[2]; end
          4'd6: begin mul_a = r_r[3]; mul_b = r_r[0]; end
          4'd7: begin mul_a = r_r[3]; mul_b = r_r[1]; end
          4'd8: begin mul_a = r_r[3]; mul_b = r_r[2]; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_OFF: begin
        mul_a = word_t'(ob_r[i2]) - word_t'(ho_r[i2]);
        mul_b = alpha_w;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    st_nxt         = st_r;
    idx_nxt        = idx_r;
    ph_nxt         = ph_r;
    sel_nxt        = sel_r;
    qa_nxt         = qa_r;
    qb_nxt         = qb_r;
    ho_nxt         = ho_r;
    ob_nxt         = ob_r;
    mv_nxt         = mv_r;
    alpha_nxt      = alpha_r;
    thr_nxt        = cfg_valid ? cfg_data : thr_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    r_nxt          = r_r;
    acc_nxt        = acc_r;
    p_nxt          = p_r;
    len_nxt        = len_r;
    dot_nxt        = dot_r;
    sin0_nxt       = sin0_r;
    w0_nxt         = w0_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    cz_nxt         = cz_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    sq_start       = 1'b0;
    sq_val         = '0;
    div_start      = 1'b0;
    div_num        = '0;
    acc_sum        = acc_r + prod_r;
    dr             = '0;
    mr             = '0;

    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_tuser) begin
            for (int k = 0; k < 4; k++) qa_nxt[k] = in_tdata[16*k +: 16];
            for (int k = 0; k < 3; k++) ho_nxt[k] = in_tdata[64 + 32*k +: 32];
          end else begin
            for (int k = 0; k < 4; k++) qb_nxt[k] = in_tdata[16*k +: 16];
            for (int k = 0; k < 3; k++) ob_nxt[k] = in_tdata[64 + 32*k +: 32];
            alpha_nxt = in_alpha;
            sel_nxt   = 1'b0;
            idx_nxt   = '0;
            ph_nxt    = 1'b0;
            acc_nxt   = '0;
            st_nxt    = ST_INSQ;
          end
        end
      end
      ST_INSQ: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          acc_nxt = acc_sum;
          idx_nxt = idx_r + 1'b1;
          if (i2 == 2'd3) begin
            idx_nxt = '0;
            if (acc_sum <= acc_t'(NEAR_ZERO_IN)) begin
              for (int k = 0; k < 4; k++) begin
                if (sel_r) begin
                  b_nxt[k] = word_t'(qb_r[k]) <<< IN_SHIFT;
                end else begin
                  a_nxt[k] = word_t'(qa_r[k]) <<< IN_SHIFT;
                end
              end
              acc_nxt = '0;
              sel_nxt = 1'b1;
              st_nxt  = sel_r ? ST_DOT : ST_INSQ;
            end else begin
              sq_start = 1'b1;
              sq_val   = acc_sum[63:0] << 30;
              st_nxt   = ST_INSQRT;
            end
          end
        end
      end
      ST_INSQRT: begin
        if (sq_done) begin
          len_nxt = {1'b0, sq_root};
          idx_nxt = '0;
          ph_nxt  = 1'b0;
          st_nxt  = ST_INDIV;
        end
      end
      ST_INDIV: begin
        div_num = 64'(qsel) <<< IN_DIV_SHIFT;
        if (!ph_r) begin
          div_start = 1'b1;
          ph_nxt    = 1'b1;
        end else if (div_done) begin
          if (sel_r) begin
            b_nxt[i2] = div_quot;
          end else begin
            a_nxt[i2] = div_quot;
          end
          ph_nxt  = 1'b0;
          idx_nxt = idx_r + 1'b1;
          if (i2 == 2'd3) begin
            idx_nxt = '0;
            acc_nxt = '0;
            sel_nxt = 1'b1;
            st_nxt  = sel_r ? ST_DOT : ST_INSQ;
          end
        end
      end
      ST_DOT: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          acc_nxt = acc_sum;
          idx_nxt = idx_r + 1'b1;
          if (i2 == 2'd3) begin
            idx_nxt = '0;
            st_nxt  = ST_DOTFIN;
          end
        end
      end
      ST_DOTFIN: begin
        dr = rsh_round(acc_r, 30);
        if (dr < 0) begin
          dr = -dr;
          for (int k = 0; k < 4; k++) b_nxt[k] = -b_r[k];
        end
        if (dr > acc_t'({thr_r, 14'd0})) begin
          st_nxt = ST_NLERP;
        end else begin
          dot_nxt = (dr > ONE_Q30) ? word_t'(ONE_Q30) : word_t'(dr);
          st_nxt  = ST_SDSQ;
        end
      end
      ST_NLERP: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          r_nxt[i2] = a_r[i2] + word_t'(rsh_round(prod_r, 16));
          idx_nxt   = idx_r + 1'b1;
          if (i2 == 2'd3) begin
            idx_nxt = '0;
            st_nxt  = ST_NQCLAMP;
          end
        end
      end
      ST_SDSQ: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          sq_start = 1'b1;
          sq_val   = 64'(ONE_Q60 - prod_r);
          st_nxt   = ST_SSQRT;
        end
      end
      ST_SSQRT: begin
        if (sq_done) begin
          sin0_nxt = word_t'(sq_root);
          cx_nxt   = dot_r;
          cy_nxt   = word_t'(sq_root);
          cz_nxt   = '0;
          idx_nxt  = '0;
          st_nxt   = ST_CANG;
        end
      end
      ST_CANG: begin
        if (cy_r >= 0) begin
          cx_nxt = cx_r + sy;
          cy_nxt = cy_r - sx;
          cz_nxt = cz_r + at;
        end else begin
          cx_nxt = cx_r - sy;
          cy_nxt = cy_r + sx;
          cz_nxt = cz_r - at;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == 5'(STEP_CNT - 1)) begin
          idx_nxt = '0;
          ph_nxt  = 1'b0;
          st_nxt  = ST_THETA;
        end
      end
      ST_THETA: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          cz_nxt  = word_t'(rsh_round(prod_r, 16));
          cx_nxt  = word_t'(ONE_Q30);
          cy_nxt  = '0;
          idx_nxt = '0;
          st_nxt  = ST_CROT;
        end
      end
      ST_CROT: begin
        if (cz_r >= 0) begin
          cx_nxt = cx_r - sy;
          cy_nxt = cy_r + sx;
          cz_nxt = cz_r - at;
        end else begin
          cx_nxt = cx_r + sy;
          cy_nxt = cy_r - sx;
          cz_nxt = cz_r + at;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == 5'(STEP_CNT - 1)) begin
          idx_nxt = '0;
          ph_nxt  = 1'b0;
          st_nxt  = ST_W0;
        end
      end
      ST_W0: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          idx_nxt = idx_r + 1'b1;
          if (!idx_r[0]) begin
            acc_nxt = prod_r;
          end else begin
            w0_nxt  = word_t'(rsh_round(acc_r - prod_r, 30));
            idx_nxt = '0;
            st_nxt  = ST_BLEND;
          end
        end
      end
      ST_BLEND: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          idx_nxt = idx_r + 1'b1;
          if (!idx_r[0]) begin
            acc_nxt = prod_r;
          end else begin
            r_nxt[idx_r[2:1]] = word_t'(rsh_round(acc_sum, 30));
            if (idx_r[2:0] == 3'd7) begin
              idx_nxt = '0;
              st_nxt  = ST_NQCLAMP;
            end
          end
        end
      end
      ST_NQCLAMP: begin
        for (int k = 0; k < 4; k++) begin
          if (r_r[k] > CLAMP_HI) begin
            r_nxt[k] = CLAMP_HI;
          end else if (r_r[k] < -CLAMP_HI) begin
            r_nxt[k] = -CLAMP_HI;
          end
        end
        acc_nxt = '0;
        idx_nxt = '0;
        ph_nxt  = 1'b0;
        st_nxt  = ST_NQSQ;
      end
      ST_NQSQ: begin
        ph_nxt  = !ph_r;
        acc_sum = acc_r + (prod_r >>> 2);
        if (ph_r) begin
          acc_nxt = acc_sum;
          idx_nxt = idx_r + 1'b1;
          if (i2 == 2'd3) begin
            idx_nxt = '0;
            if (acc_sum <= acc_t'(NEAR_ZERO_Q58)) begin
              st_nxt = ST_MATP;
            end else begin
              sq_start = 1'b1;
              sq_val   = acc_sum[63:0];
              st_nxt   = ST_NQSQRT;
            end
          end
        end
      end
      ST_NQSQRT: begin
        if (sq_done) begin
          len_nxt = {1'b0, sq_root};
          idx_nxt = '0;
          ph_nxt  = 1'b0;
          st_nxt  = ST_NQDIV;
        end
      end
      ST_NQDIV: begin
        div_num = 64'(r_r[i2]) <<< NQ_DIV_SHIFT;
        if (!ph_r) begin
          div_start = 1'b1;
          ph_nxt    = 1'b1;
        end else if (div_done) begin
          r_nxt[i2] = div_quot;
          ph_nxt    = 1'b0;
          idx_nxt   = idx_r + 1'b1;
          if (i2 == 2'd3) begin
            idx_nxt = '0;
            st_nxt  = ST_MATP;
          end
        end
      end
      ST_MATP: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          p_nxt[i4] = prod_r;
          idx_nxt   = idx_r + 1'b1;
          if (i4 == 4'd8) begin
            idx_nxt = '0;
            st_nxt  = ST_OFF;
          end
        end
      end
      ST_OFF: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          mr = acc_t'(ho_r[i2]) + rsh_round(prod_r, 16);
          if (mr > acc_t'(32'sh7fffffff)) begin
            mv_nxt[i2] = 32'sh7fffffff;
          end else if (mr < -acc_t'(32'sh7fffffff) - 1) begin
            mv_nxt[i2] = 32'sh80000000;
          end else begin
            mv_nxt[i2] = mr[31:0];
          end
          idx_nxt = idx_r + 1'b1;
          if (i2 == 2'd2) begin
            idx_nxt = '0;
            st_nxt  = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {6'd0, mv_r[2], mv_r[1], mv_r[0], ent[8], ent[7], ent[6],
                            ent[5], ent[4], ent[3], ent[2], ent[1], ent[0]};
          st_nxt         = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      idx_r        <= '0;
      ph_r         <= 1'b0;
      sel_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
      thr_r        <= 17'd65503;
      for (int k = 0; k < 4; k++) qa_r[k] <= '0;
      for (int k = 0; k < 3; k++) ho_r[k] <= '0;
    end else begin
      st_r         <= st_nxt;
      idx_r        <= idx_nxt;
      ph_r         <= ph_nxt;
      sel_r        <= sel_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      thr_r        <= thr_nxt;
      qa_r         <= qa_nxt;
      ho_r         <= ho_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qb_r        <= qb_nxt;
    ob_r        <= ob_nxt;
    mv_r        <= mv_nxt;
    alpha_r     <= alpha_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    r_r         <= r_nxt;
    acc_r       <= acc_nxt;
    p_r         <= p_nxt;
    len_r       <= len_nxt;
    dot_r       <= dot_nxt;
    sin0_r      <= sin0_nxt;
    w0_r        <= w0_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    cz_r        <= cz_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

`ifndef SYNTHESIS
  a_sqrt_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> (st_r == ST_INSQRT || st_r == ST_SSQRT || st_r == ST_NQSQRT))
    else $error("root result outside a root wait state");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> ((st_r == ST_INDIV || st_r == ST_NQDIV) && ph_r))
    else $error("quotient outside a divide wait state");

  a_blend_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser) |=> !in_tready)
    else $error("blend beat did not start the sequencer");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(st_r) == ST_DONE)
    else $error("result raised outside the done state");
`endif

endmodule
